>>> rtl/csid_pkg.sv
// Shared types, constants and match functions for the cookie session id extractor.
package csid_pkg;

   // Longest identifier kept and the store that holds it.
   localparam int MAX_ID_LEN  = 64;
   localparam int STORE_DEPTH = 64;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   // Keyword lengths and match position widths.
   localparam int COOKIE_LEN   = 7;
   localparam int KEY_LEN      = 8;
   localparam int COOKIE_POS_W = 3;
   localparam int KEY_POS_W    = 4;
   localparam int KEY_IDX_W    = 3;

   localparam logic [7:0] COOKIE_PAT [COOKIE_LEN] = '{"c", "o", "o", "k", "i", "e", ":"};
   localparam logic [7:0] KEY_PAT [KEY_LEN] = '{"s", "e", "s", "s", "_", "i", "d", "="};
   localparam logic [KEY_POS_W-1:0] KEY_FAIL [KEY_LEN] = '{
      4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0};

   // Value terminators.
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic rd_issue;
      logic load_run;
   } csid_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic start_run;
      logic run_last;
      logic slot_free;
   } csid_sts_type;

   // Only A-Z are folded to lower case.
   function automatic logic [7:0] fold_case(input logic [7:0] ch);
      if (ch >= "A" && ch <= "Z") begin
         return ch + 8'd32;
      end
      return ch;
   endfunction

   function automatic logic is_terminator(input logic [7:0] ch);
      return (ch == CH_SPACE) || (ch == CH_SEMI) || (ch == CH_COMMA) ||
             (ch == CH_CR) || (ch == CH_LF);
   endfunction

   // The cookie keyword has no internal border, so a miss restarts at the first letter.
   function automatic logic [COOKIE_POS_W-1:0] cookie_step(
      input logic [COOKIE_POS_W-1:0] pos, input logic [7:0] ch);
      if (COOKIE_PAT[pos] == ch) begin
         return pos + 1'b1;
      end
      if (COOKIE_PAT[0] == ch) begin
         return COOKIE_POS_W'(1);
      end
      return '0;
   endfunction

   // The key keyword falls back along its borders; the chain is at most three steps.
   function automatic logic [KEY_POS_W-1:0] key_step(
      input logic [KEY_POS_W-1:0] pos, input logic [7:0] ch);
      logic [KEY_POS_W-1:0] p;
      logic [KEY_POS_W-1:0] r;
      logic                 done;
      p    = pos;
      r    = '0;
      done = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (!done) begin
            if (KEY_PAT[p[KEY_IDX_W-1:0]] == ch) begin
               r    = p + 1'b1;
               done = 1'b1;
            end else if (p == '0) begin
               done = 1'b1;
            end else begin
               p = KEY_FAIL[p[KEY_IDX_W-1:0]];
            end
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/csid_ctrl.sv
// Controller that sequences byte intake and the read-out of an identifier run.
module csid_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  csid_pkg::csid_sts_type sts,
   output csid_pkg::csid_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_SCAN,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type state_ff;

   // Bytes are taken only while scanning and the output slot can take a result.
   always_comb begin
      req_ready    = (state_ff == ST_SCAN) && sts.slot_free;
      cmd.accept   = req_ready && req_valid;
      cmd.rd_issue = (state_ff == ST_READ);
      cmd.load_run = (state_ff == ST_LOAD) && sts.slot_free;
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SCAN;
      end else begin
         unique case (state_ff)
            ST_SCAN: begin
               if (cmd.accept && sts.start_run) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               if (sts.slot_free) begin
                  state_ff <= sts.run_last ? ST_SCAN : ST_READ;
               end
            end
            default: begin
               state_ff <= ST_SCAN;
            end
         endcase
      end
   end

endmodule

>>> rtl/csid_dp.sv
// Datapath: keyword matchers, value store, run counters and the output register.
module csid_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_header_byte,
   input  logic                   req_end_of_header,
   output logic [7:0]             rsp_id_byte,
   output logic                   rsp_found,
   output logic                   rsp_last_of_run,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  csid_pkg::csid_cmd_type cmd,
   output csid_pkg::csid_sts_type sts
);

   typedef enum logic [1:0] {
      PH_COOKIE,
      PH_KEY,
      PH_VALUE,
      PH_DONE
   } phase_type;

   phase_type                           phase_ff, phase_in;
   logic [csid_pkg::COOKIE_POS_W-1:0]   cookie_pos_ff, cookie_pos_in;
   logic [csid_pkg::KEY_POS_W-1:0]      key_pos_ff, key_pos_in;
   logic [csid_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [csid_pkg::CNT_W-1:0]          run_len_ff;
   logic [csid_pkg::CNT_W-1:0]          rd_idx_ff;
   logic [7:0]                          rd_data_ff;
   logic [7:0]                          store_mem [csid_pkg::STORE_DEPTH];
   logic                                rsp_valid_ff;
   logic [7:0]                          id_byte_ff;
   logic                                found_ff;
   logic                                last_ff;

   logic [7:0]                          lc;
   logic                                term;
   logic [csid_pkg::COOKIE_POS_W-1:0]   cookie_next;
   logic [csid_pkg::KEY_POS_W-1:0]      key_next;
   logic                                single;
   logic                                start_run;
   logic                                wr_en;
   logic                                load_single;

   assign lc          = csid_pkg::fold_case(req_header_byte);
   assign term        = csid_pkg::is_terminator(req_header_byte);
   assign cookie_next = csid_pkg::cookie_step(cookie_pos_ff, lc);
   assign key_next    = csid_pkg::key_step(key_pos_ff, lc);

   // Parser step for the byte on the request port.
   always_comb begin
      phase_in      = phase_ff;
      cookie_pos_in = cookie_pos_ff;
      key_pos_in    = key_pos_ff;
      count_in      = count_ff;
      single        = 1'b0;
      start_run     = 1'b0;
      wr_en         = 1'b0;
      unique case (phase_ff)
         PH_COOKIE: begin
            if (cookie_next == csid_pkg::COOKIE_POS_W'(csid_pkg::COOKIE_LEN)) begin
               cookie_pos_in = '0;
               phase_in      = PH_KEY;
            end else begin
               cookie_pos_in = cookie_next;
            end
         end
         PH_KEY: begin
            if (key_next == csid_pkg::KEY_POS_W'(csid_pkg::KEY_LEN)) begin
               key_pos_in = '0;
               count_in   = '0;
               phase_in   = PH_VALUE;
            end else begin
               key_pos_in = key_next;
            end
         end
         PH_VALUE: begin
            if (term) begin
               if (count_ff == '0) begin
                  single = 1'b1;
               end else begin
                  start_run = 1'b1;
               end
               phase_in = PH_DONE;
            end else if (count_ff < csid_pkg::CNT_W'(csid_pkg::MAX_ID_LEN)) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase
      // The final byte reports a miss if nothing was given yet, then rearms.
      if (req_end_of_header) begin
         if (phase_in != PH_DONE) begin
            single = 1'b1;
         end
         phase_in      = PH_COOKIE;
         cookie_pos_in = '0;
         key_pos_in    = '0;
         count_in      = '0;
      end
   end

   assign load_single   = cmd.accept && single;
   assign sts.start_run = start_run;
   assign sts.run_last  = (rd_idx_ff == run_len_ff - 1'b1);
   assign sts.slot_free = !rsp_valid_ff || rsp_ready;

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_COOKIE;
         cookie_pos_ff <= '0;
         key_pos_ff    <= '0;
         count_ff      <= '0;
      end else if (cmd.accept) begin
         phase_ff      <= phase_in;
         cookie_pos_ff <= cookie_pos_in;
         key_pos_ff    <= key_pos_in;
         count_ff      <= count_in;
      end
   end

   // Value store, written while collecting and read back during a run.
   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         store_mem[count_ff[csid_pkg::IDX_W-1:0]] <= req_header_byte;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= store_mem[rd_idx_ff[csid_pkg::IDX_W-1:0]];
      end
   end

   // Run length and read pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_len_ff <= '0;
         rd_idx_ff  <= '0;
      end else if (cmd.accept && start_run) begin
         run_len_ff <= count_ff;
         rd_idx_ff  <= '0;
      end else if (cmd.load_run) begin
         rd_idx_ff <= rd_idx_ff + 1'b1;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_single || cmd.load_run) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_single) begin
         id_byte_ff <= '0;
         found_ff   <= 1'b0;
         last_ff    <= 1'b1;
      end else if (cmd.load_run) begin
         id_byte_ff <= rd_data_ff;
         found_ff   <= 1'b1;
         last_ff    <= sts.run_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_id_byte     = id_byte_ff;
   assign rsp_found       = found_ff;
   assign rsp_last_of_run = last_ff;

endmodule

>>> rtl/cookie_session_id_extractor.sv
// Top level of the cookie session id extractor: controller, datapath and checks.
// Scanning takes one header byte per cycle while the output slot can take a result.
// A miss result appears in the output register in the cycle after its byte is taken.
// An identifier is read from the value store byte by byte, a read state then a load state
// per byte; a load waits for a free output slot, and no header byte is taken meanwhile.
// Synchronous active-high reset clears the parser, the run counters and the output valid.
module cookie_session_id_extractor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_header_byte,
   input  logic       req_end_of_header,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_id_byte,
   output logic       rsp_found,
   output logic       rsp_last_of_run
);

   csid_pkg::csid_cmd_type cmd;
   csid_pkg::csid_sts_type sts;

   // Sequencer.
   csid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Parser, store and output register.
   csid_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_header_byte   (req_header_byte),
      .req_end_of_header (req_end_of_header),
      .rsp_id_byte       (rsp_id_byte),
      .rsp_found         (rsp_found),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .cmd               (cmd),
      .sts               (sts)
   );

`ifndef SYNTHESIS
   // A miss result is always a lone, zeroed, final result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_last_of_run && rsp_id_byte == 8'd0))
      else $error("miss result is not a zeroed final result");

   // A request that starts a run stops intake in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && sts.start_run) |=> !req_ready)
      else $error("intake continued after a run started");

   // The datapath is never asked to read the store while taking a request.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && (cmd.rd_issue || cmd.load_run)))
      else $error("request taken during a run");
`endif

endmodule
